// ===== rtl/pmg3d_pkg.sv =====
// shared types, widths and codes for the pose mahalanobis gate
// no dependencies; every other rtl file refers to this package by scoped names
package pmg3d_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   // pi with 48 fraction bits, rounded to nearest at the fraction width in use
   localparam logic [63:0] PI_Q48 = 64'h0003_243F_6A88_85A3;

   localparam int SW    = 33;   // innovation and covariance sums
   localparam int PW    = 66;   // product of two of those
   localparam int AW    = 67;   // adjugate entry
   localparam int DW    = 102;  // determinant
   localparam int QW    = 138;  // quadratic form
   localparam int QUO_W = 32;   // distance result

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FILT_COV_XX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILT_COV_XY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILT_COV_XH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILT_COV_YY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILT_COV_YH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILT_COV_HH = 3'd5;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOT_PD = 2'd1,
      ST_SAT    = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [31:0] prop_x;
      logic signed [31:0] prop_y;
      logic signed [31:0] prop_heading;
      logic signed [31:0] est_x;
      logic signed [31:0] est_y;
      logic signed [31:0] est_heading;
      logic        [30:0] meas_cov_xx;
      logic signed [31:0] meas_cov_xy;
      logic signed [31:0] meas_cov_xh;
      logic        [30:0] meas_cov_yy;
      logic signed [31:0] meas_cov_yh;
      logic        [30:0] meas_cov_hh;
   } req_type;

   typedef struct packed {
      logic        [30:0] filt_cov_xx;
      logic signed [31:0] filt_cov_xy;
      logic signed [31:0] filt_cov_xh;
      logic        [30:0] filt_cov_yy;
      logic signed [31:0] filt_cov_yh;
      logic        [30:0] filt_cov_hh;
   } cfg_type;

   typedef struct packed {
      logic signed [SW-1:0] ix;
      logic signed [SW-1:0] iy;
      logic signed [SW-1:0] ih;
      logic signed [SW-1:0] s00;
      logic signed [SW-1:0] s01;
      logic signed [SW-1:0] s02;
      logic signed [SW-1:0] s11;
      logic signed [SW-1:0] s12;
      logic signed [SW-1:0] s22;
   } front_type;

   typedef struct packed {
      logic signed [QW-1:0] q;
      logic signed [DW-1:0] det;
      logic                 not_pd;
   } quad_type;

endpackage

// ===== rtl/pmg3d_front.sv =====
// front stage: innovation and S = measurement plus filter covariance
// depends on pmg3d_pkg
module pmg3d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pmg3d_pkg::req_type   in_req,
   input  pmg3d_pkg::cfg_type   cfg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pmg3d_pkg::front_type out_data
);

   localparam int SW = pmg3d_pkg::SW;

   logic                 vld_ff;
   pmg3d_pkg::front_type data_ff;
   pmg3d_pkg::front_type data_in;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      data_in.ix  = SW'($signed(in_req.prop_x)) - SW'($signed(in_req.est_x));
      data_in.iy  = SW'($signed(in_req.prop_y)) - SW'($signed(in_req.est_y));
      data_in.ih  = SW'($signed(in_req.prop_heading)) - SW'($signed(in_req.est_heading));
      data_in.s00 = $signed({2'b00, in_req.meas_cov_xx}) + $signed({2'b00, cfg.filt_cov_xx});
      data_in.s11 = $signed({2'b00, in_req.meas_cov_yy}) + $signed({2'b00, cfg.filt_cov_yy});
      data_in.s22 = $signed({2'b00, in_req.meas_cov_hh}) + $signed({2'b00, cfg.filt_cov_hh});
      data_in.s01 = SW'($signed(in_req.meas_cov_xy)) + SW'($signed(cfg.filt_cov_xy));
      data_in.s02 = SW'($signed(in_req.meas_cov_xh)) + SW'($signed(cfg.filt_cov_xh));
      data_in.s12 = SW'($signed(in_req.meas_cov_yh)) + SW'($signed(cfg.filt_cov_yh));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/pmg3d_wrap.sv =====
// heading wrap into [-pi, pi] over four stages, reciprocal multiply by 1/(2 pi)
// depends on pmg3d_pkg
module pmg3d_wrap #(
   parameter int FRAC_BITS = pmg3d_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pmg3d_pkg::front_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pmg3d_pkg::front_type out_data
);

   localparam int SW = pmg3d_pkg::SW;
   localparam int HW = SW + 2;
   localparam int NW = 34;
   localparam int NS = 4;

   localparam longint unsigned PI_VAL =
      (pmg3d_pkg::PI_Q48 + (64'd1 << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
   localparam longint unsigned TWO_PI = 2 * PI_VAL;
   localparam longint unsigned RECIP  = (64'd1 << NW) / TWO_PI;
   localparam int TW  = $clog2(TWO_PI + 1);
   localparam int RCW = $clog2(RECIP + 1);

   localparam logic signed [HW-1:0] PI_S     = HW'(PI_VAL);
   localparam logic signed [HW-1:0] ONE_S    = HW'(1);
   localparam logic        [NW-1:0] TWO_PI_N = NW'(TWO_PI);
   localparam logic        [TW-1:0] TWO_PI_T = TW'(TWO_PI);
   localparam logic       [RCW-1:0] RECIP_R  = RCW'(RECIP);

   typedef enum logic [1:0] {WRAP_NONE, WRAP_DOWN, WRAP_UP} wrap_mode_type;

   typedef struct packed {
      pmg3d_pkg::front_type f;
      wrap_mode_type        mode;
      logic [NW-1:0]        n;
   } w0_type;

   typedef struct packed {
      pmg3d_pkg::front_type f;
      wrap_mode_type        mode;
      logic [NW-1:0]        n;
      logic [RCW-1:0]       q0;
   } w1_type;

   typedef struct packed {
      pmg3d_pkg::front_type f;
      wrap_mode_type        mode;
      logic [NW-1:0]        n;
      logic [NW-1:0]        p;
   } w2_type;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   adv;

   w0_type w0_ff, w0_in;
   w1_type w1_ff, w1_in;
   w2_type w2_ff, w2_in;
   pmg3d_pkg::front_type w3_ff, w3_in;

   logic signed [HW-1:0] h0;
   logic signed [HW-1:0] h3;
   logic [NW+RCW-1:0]    prod1;
   logic [RCW+TW-1:0]    prod2;
   logic [NW-1:0]        rem3;
   logic [NW-1:0]        adj3;

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = in_valid;
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign in_ready = adv[0];

   // case split and numerator for the ceiling quotient
   always_comb begin
      h0      = HW'($signed(in_data.ih));
      w0_in.f = in_data;
      if (h0 > PI_S) begin
         w0_in.mode = WRAP_DOWN;
         w0_in.n    = NW'(h0 + PI_S - ONE_S);
      end else if (h0 < -PI_S) begin
         w0_in.mode = WRAP_UP;
         w0_in.n    = NW'(PI_S - ONE_S - h0);
      end else begin
         w0_in.mode = WRAP_NONE;
         w0_in.n    = '0;
      end
   end

   // quotient estimate, at most one short
   always_comb begin
      prod1       = w0_ff.n * RECIP_R;
      w1_in.f     = w0_ff.f;
      w1_in.mode  = w0_ff.mode;
      w1_in.n     = w0_ff.n;
      w1_in.q0    = prod1[NW +: RCW];
   end

   always_comb begin
      prod2      = w1_ff.q0 * TWO_PI_T;
      w2_in.f    = w1_ff.f;
      w2_in.mode = w1_ff.mode;
      w2_in.n    = w1_ff.n;
      w2_in.p    = NW'(prod2);
   end

   // correction and final shift by whole turns
   always_comb begin
      rem3  = w2_ff.n - w2_ff.p;
      adj3  = (rem3 >= TWO_PI_N) ? (w2_ff.p + TWO_PI_N) : w2_ff.p;
      h3    = HW'($signed(w2_ff.f.ih));
      w3_in = w2_ff.f;
      case (w2_ff.mode)
         WRAP_DOWN: begin
            w3_in.ih = SW'(h3 - $signed({1'b0, adj3}));
         end
         WRAP_UP: begin
            w3_in.ih = SW'(h3 + $signed({1'b0, adj3}));
         end
         default: begin
            w3_in.ih = w2_ff.f.ih;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         w0_ff <= w0_in;
      end
      if (adv[1]) begin
         w1_ff <= w1_in;
      end
      if (adv[2]) begin
         w2_ff <= w2_in;
      end
      if (adv[3]) begin
         w3_ff <= w3_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_data  = w3_ff;

endmodule

// ===== rtl/pmg3d_quad.sv =====
// adjugate, determinant and quadratic form innov' adj(S) innov in five stages
// depends on pmg3d_pkg; wide products are split into 32-bit limbs
module pmg3d_quad (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pmg3d_pkg::front_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pmg3d_pkg::quad_type  out_data
);

   localparam int SW = pmg3d_pkg::SW;
   localparam int PW = pmg3d_pkg::PW;
   localparam int AW = pmg3d_pkg::AW;
   localparam int DW = pmg3d_pkg::DW;
   localparam int QW = pmg3d_pkg::QW;
   localparam int NS = 5;
   localparam int NT = 6;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   adv;

   // stage 1: plain products
   logic signed [SW-1:0] s0_1_ff [3];
   logic signed [SW-1:0] s0_1_in [3];
   logic signed [PW-1:0] pa1_ff [NT];
   logic signed [PW-1:0] pa1_in [NT];
   logic signed [PW-1:0] pb1_ff [NT];
   logic signed [PW-1:0] pb1_in [NT];
   logic signed [PW-1:0] ip1_ff [NT];
   logic signed [PW-1:0] ip1_in [NT];

   // stage 2: adjugate entries, order a00 a11 a22 a01 a02 a12
   logic signed [SW-1:0] s0_2_ff [3];
   logic signed [AW-1:0] a2_ff [NT];
   logic signed [AW-1:0] a2_in [NT];
   logic signed [PW-1:0] ip2_ff [NT];
   logic                 pd2_ff;
   logic                 pd2_in;

   // stage 3: limb products
   logic signed [SW+AW-32-1:0] dh3_ff [3];
   logic signed [SW+AW-32-1:0] dh3_in [3];
   logic signed [SW+33-1:0]    dl3_ff [3];
   logic signed [SW+33-1:0]    dl3_in [3];
   logic signed [AW+PW-64-1:0] hh3_ff [NT];
   logic signed [AW+PW-64-1:0] hh3_in [NT];
   logic signed [AW-32+33-1:0] hl3_ff [NT];
   logic signed [AW-32+33-1:0] hl3_in [NT];
   logic signed [PW-32+33-1:0] lh3_ff [NT];
   logic signed [PW-32+33-1:0] lh3_in [NT];
   logic        [63:0]         ll3_ff [NT];
   logic        [63:0]         ll3_in [NT];
   logic                       pd3_ff;

   // stage 4: recombined terms
   logic signed [QW-1:0] term4_ff [NT];
   logic signed [QW-1:0] term4_in [NT];
   logic signed [DW-1:0] det4_ff;
   logic signed [DW-1:0] det4_in;
   logic                 pd4_ff;

   pmg3d_pkg::quad_type  q5_ff;
   pmg3d_pkg::quad_type  q5_in;

   logic signed [AW-1:0] a_det;

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = in_valid;
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      s0_1_in[0] = in_data.s00;
      s0_1_in[1] = in_data.s01;
      s0_1_in[2] = in_data.s02;
      pa1_in[0] = $signed(in_data.s11) * $signed(in_data.s22);
      pb1_in[0] = $signed(in_data.s12) * $signed(in_data.s12);
      pa1_in[1] = $signed(in_data.s00) * $signed(in_data.s22);
      pb1_in[1] = $signed(in_data.s02) * $signed(in_data.s02);
      pa1_in[2] = $signed(in_data.s00) * $signed(in_data.s11);
      pb1_in[2] = $signed(in_data.s01) * $signed(in_data.s01);
      pa1_in[3] = $signed(in_data.s02) * $signed(in_data.s12);
      pb1_in[3] = $signed(in_data.s01) * $signed(in_data.s22);
      pa1_in[4] = $signed(in_data.s01) * $signed(in_data.s12);
      pb1_in[4] = $signed(in_data.s02) * $signed(in_data.s11);
      pa1_in[5] = $signed(in_data.s01) * $signed(in_data.s02);
      pb1_in[5] = $signed(in_data.s00) * $signed(in_data.s12);
      ip1_in[0] = $signed(in_data.ix) * $signed(in_data.ix);
      ip1_in[1] = $signed(in_data.iy) * $signed(in_data.iy);
      ip1_in[2] = $signed(in_data.ih) * $signed(in_data.ih);
      ip1_in[3] = $signed(in_data.ix) * $signed(in_data.iy);
      ip1_in[4] = $signed(in_data.ix) * $signed(in_data.ih);
      ip1_in[5] = $signed(in_data.iy) * $signed(in_data.ih);
   end

   always_comb begin
      for (int k = 0; k < NT; k++) begin
         a2_in[k] = AW'(pa1_ff[k]) - AW'(pb1_ff[k]);
      end
      // leading minors of order one and two
      pd2_in = (s0_1_ff[0] > 0) && (a2_in[2] > 0);
   end

   always_comb begin
      a_det = '0;
      for (int j = 0; j < 3; j++) begin
         case (j)
            0:       a_det = a2_ff[0];
            1:       a_det = a2_ff[3];
            default: a_det = a2_ff[4];
         endcase
         dh3_in[j] = s0_2_ff[j] * $signed(a_det[AW-1:32]);
         dl3_in[j] = s0_2_ff[j] * $signed({1'b0, a_det[31:0]});
      end
      for (int k = 0; k < NT; k++) begin
         hh3_in[k] = $signed(a2_ff[k][AW-1:32]) * $signed(ip2_ff[k][PW-1:32]);
         hl3_in[k] = $signed(a2_ff[k][AW-1:32]) * $signed({1'b0, ip2_ff[k][31:0]});
         lh3_in[k] = $signed({1'b0, a2_ff[k][31:0]}) * $signed(ip2_ff[k][PW-1:32]);
         ll3_in[k] = a2_ff[k][31:0] * ip2_ff[k][31:0];
      end
   end

   always_comb begin
      det4_in = '0;
      for (int j = 0; j < 3; j++) begin
         det4_in = det4_in + (DW'(dh3_ff[j]) <<< 32) + DW'(dl3_ff[j]);
      end
      for (int k = 0; k < NT; k++) begin
         term4_in[k] = (QW'(hh3_ff[k]) <<< 64) + (QW'(hl3_ff[k]) <<< 32)
                     + (QW'(lh3_ff[k]) <<< 32) + QW'($signed({1'b0, ll3_ff[k]}));
      end
   end

   always_comb begin
      // off-diagonal terms appear twice
      q5_in.q      = term4_ff[0] + term4_ff[1] + term4_ff[2]
                   + ((term4_ff[3] + term4_ff[4] + term4_ff[5]) <<< 1);
      q5_in.det    = det4_ff;
      q5_in.not_pd = !(pd4_ff && (det4_ff > 0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_1_ff <= s0_1_in;
         pa1_ff  <= pa1_in;
         pb1_ff  <= pb1_in;
         ip1_ff  <= ip1_in;
      end
      if (adv[1]) begin
         s0_2_ff <= s0_1_ff;
         a2_ff   <= a2_in;
         ip2_ff  <= ip1_ff;
         pd2_ff  <= pd2_in;
      end
      if (adv[2]) begin
         dh3_ff <= dh3_in;
         dl3_ff <= dl3_in;
         hh3_ff <= hh3_in;
         hl3_ff <= hl3_in;
         lh3_ff <= lh3_in;
         ll3_ff <= ll3_in;
         pd3_ff <= pd2_ff;
      end
      if (adv[3]) begin
         term4_ff <= term4_in;
         det4_ff  <= det4_in;
         pd4_ff   <= pd3_ff;
      end
      if (adv[4]) begin
         q5_ff <= q5_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_data  = q5_ff;

endmodule

// ===== rtl/pmg3d_div.sv =====
// range check and pipelined restoring divide, one quotient bit per stage
// depends on pmg3d_pkg
module pmg3d_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pmg3d_pkg::quad_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [pmg3d_pkg::QUO_W-1:0] out_dist_sq,
   output pmg3d_pkg::status_type out_status
);

   localparam int DW    = pmg3d_pkg::DW;
   localparam int QW    = pmg3d_pkg::QW;
   localparam int QUO_W = pmg3d_pkg::QUO_W;
   localparam int RW    = DW + QUO_W;
   localparam int NS    = QUO_W + 1;

   typedef struct packed {
      logic [RW-1:0]         rem;
      logic [DW-1:0]         den;
      logic [QUO_W-1:0]      quo;
      pmg3d_pkg::status_type status;
   } div_type;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   adv;

   div_type st_ff [NS];
   div_type st_in [NS];

   logic signed [QW-1:0] lim;
   logic [RW-1:0]        dsh;

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = in_valid;
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      lim          = QW'($signed(in_data.det)) <<< QUO_W;
      st_in[0].rem = RW'(in_data.q);
      st_in[0].den = in_data.det;
      st_in[0].quo = '0;
      if (in_data.not_pd) begin
         st_in[0].status = pmg3d_pkg::ST_NOT_PD;
      end else if ($signed(in_data.q) >= lim) begin
         st_in[0].status = pmg3d_pkg::ST_SAT;
      end else begin
         st_in[0].status = pmg3d_pkg::ST_OK;
      end
      dsh = '0;
      for (int i = 1; i < NS; i++) begin
         st_in[i] = st_ff[i-1];
         dsh      = RW'(st_ff[i-1].den) << (QUO_W - i);
         if (st_ff[i-1].rem >= dsh) begin
            st_in[i].rem             = st_ff[i-1].rem - dsh;
            st_in[i].quo[QUO_W - i]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      out_status = st_ff[NS-1].status;
      case (st_ff[NS-1].status)
         pmg3d_pkg::ST_OK: begin
            out_dist_sq = st_ff[NS-1].quo;
         end
         pmg3d_pkg::ST_SAT: begin
            out_dist_sq = '1;
         end
         default: begin
            out_dist_sq = '0;
         end
      endcase
   end

   assign out_valid = vld_ff[NS-1];

endmodule

// ===== rtl/pose_mahalanobis_gate_3d_unit.sv =====
// top level of the pose mahalanobis gate: csr block and the pipeline chain
// depends on pmg3d_pkg, pmg3d_front, pmg3d_wrap, pmg3d_quad, pmg3d_div
//
// usage
// - a request carries a proposed pose, the pose estimate and the measurement
//   covariance; each request gives exactly one response with dist_sq and status
// - req_* and rsp_* are valid/ready channels; a request is taken when
//   req_valid and req_ready are high at a rising edge, likewise a response
// - the chain has 1 front stage, 4 heading-wrap stages, 5 stages of
//   adjugate, determinant and quadratic form, 1 range check and 32 divide
//   stages, one quotient bit each (the restoring divider sets the depth)
// - one request per cycle while rsp_ready is high; the widest 35 by 34 limb
//   multipliers and a 134-bit compare-subtract per divide stage set the period
// - when the receiver stalls, each stage holds while the next is full, so
//   bubbles close up and requests are still taken until the chain is full
// - csr writes (csr_write_en, csr_index, csr_wdata) load the filter
//   covariance; write only while no request is in flight
// - synchronous reset clears the filter covariance and every valid bit
module pose_mahalanobis_gate_3d_unit #(
   parameter int FRAC_BITS = pmg3d_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [31:0]                  req_prop_x,
   input  logic signed [31:0]                  req_prop_y,
   input  logic signed [31:0]                  req_prop_heading,
   input  logic signed [31:0]                  req_est_x,
   input  logic signed [31:0]                  req_est_y,
   input  logic signed [31:0]                  req_est_heading,
   input  logic        [30:0]                  req_meas_cov_xx,
   input  logic signed [31:0]                  req_meas_cov_xy,
   input  logic signed [31:0]                  req_meas_cov_xh,
   input  logic        [30:0]                  req_meas_cov_yy,
   input  logic signed [31:0]                  req_meas_cov_yh,
   input  logic        [30:0]                  req_meas_cov_hh,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [31:0]                         rsp_dist_sq,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_write_en,
   input  logic [pmg3d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pmg3d_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pmg3d_pkg::cfg_type    cfg_ff;
   pmg3d_pkg::cfg_type    cfg_in;
   pmg3d_pkg::req_type    req;
   pmg3d_pkg::front_type  front_data;
   pmg3d_pkg::front_type  wrap_data;
   pmg3d_pkg::quad_type   quad_data;
   pmg3d_pkg::status_type div_status;

   logic front_valid, front_ready;
   logic wrap_valid, wrap_ready;
   logic quad_valid, quad_ready;

   // filter covariance registers, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pmg3d_pkg::CSR_FILT_COV_XX: cfg_in.filt_cov_xx = csr_wdata[30:0];
            pmg3d_pkg::CSR_FILT_COV_XY: cfg_in.filt_cov_xy = csr_wdata;
            pmg3d_pkg::CSR_FILT_COV_XH: cfg_in.filt_cov_xh = csr_wdata;
            pmg3d_pkg::CSR_FILT_COV_YY: cfg_in.filt_cov_yy = csr_wdata[30:0];
            pmg3d_pkg::CSR_FILT_COV_YH: cfg_in.filt_cov_yh = csr_wdata;
            pmg3d_pkg::CSR_FILT_COV_HH: cfg_in.filt_cov_hh = csr_wdata[30:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // gather the request fields
   always_comb begin
      req.prop_x       = req_prop_x;
      req.prop_y       = req_prop_y;
      req.prop_heading = req_prop_heading;
      req.est_x        = req_est_x;
      req.est_y        = req_est_y;
      req.est_heading  = req_est_heading;
      req.meas_cov_xx  = req_meas_cov_xx;
      req.meas_cov_xy  = req_meas_cov_xy;
      req.meas_cov_xh  = req_meas_cov_xh;
      req.meas_cov_yy  = req_meas_cov_yy;
      req.meas_cov_yh  = req_meas_cov_yh;
      req.meas_cov_hh  = req_meas_cov_hh;
   end

   // innovation and S
   pmg3d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_req    (req),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // heading difference folded into one turn
   pmg3d_wrap #(
      .FRAC_BITS (FRAC_BITS)
   ) u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (wrap_valid),
      .out_ready (wrap_ready),
      .out_data  (wrap_data)
   );

   // exact numerator and denominator of the distance
   pmg3d_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wrap_valid),
      .in_ready  (wrap_ready),
      .in_data   (wrap_data),
      .out_valid (quad_valid),
      .out_ready (quad_ready),
      .out_data  (quad_data)
   );

   // truncating divide with saturation and the not positive definite case
   pmg3d_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (quad_valid),
      .in_ready    (quad_ready),
      .in_data     (quad_data),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_dist_sq (rsp_dist_sq),
      .out_status  (div_status)
   );

   assign rsp_status = div_status;

   // checks
   a_not_pd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pmg3d_pkg::ST_NOT_PD) |-> (rsp_dist_sq == 32'd0))
      else $error("not positive definite response with nonzero distance");

   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pmg3d_pkg::ST_SAT) |-> (rsp_dist_sq == 32'hFFFF_FFFF))
      else $error("saturated response without full-scale distance");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && csr_index == pmg3d_pkg::CSR_FILT_COV_XY)
         |=> (cfg_ff.filt_cov_xy == $past(csr_wdata)))
      else $error("filter covariance write lost");

endmodule

// ===== sim/pose_mahalanobis_gate_3d_unit_tb.sv =====
// self-checking testbench for the pose mahalanobis gate top level
// depends on pmg3d_pkg and the rtl of pose_mahalanobis_gate_3d_unit
`timescale 1ns / 1ps

module pose_mahalanobis_gate_3d_unit_tb;

   localparam int FRAC  = 16;
   localparam int REQ_W = $bits(pmg3d_pkg::req_type);
   // wide enough for every intermediate of the gate
   typedef logic signed [159:0] wide_type;

   // expected distance and status for one request, worked out exactly in wide integers
   class gate_scoreboard;
      typedef struct {
         logic [31:0]           dist_val;
         pmg3d_pkg::status_type st;
      } verdict_type;

      verdict_type expected_q[$];
      int          mismatches;

      function longint wrap_heading(longint h);
         longint pi, tp, k;
         pi = longint'((pmg3d_pkg::PI_Q48 + (64'd1 << (47 - FRAC))) >> (48 - FRAC));
         tp = 2 * pi;
         if (h > pi) begin
            k = (h - pi + tp - 1) / tp;
            h -= k * tp;
         end else if (h < -pi) begin
            k = (-pi - h + tp - 1) / tp;
            h += k * tp;
         end
         return h;
      endfunction

      function void note(pmg3d_pkg::req_type r, pmg3d_pkg::cfg_type c);
         longint      ix, iy, ih, s00, s01, s02, s11, s12, s22;
         wide_type    a00, a01, a02, a11, a12, a22, det, q, cr, lim;
         verdict_type v;
         ix  = longint'($signed(r.prop_x)) - longint'($signed(r.est_x));
         iy  = longint'($signed(r.prop_y)) - longint'($signed(r.est_y));
         ih  = wrap_heading(longint'($signed(r.prop_heading))
                            - longint'($signed(r.est_heading)));
         s00 = longint'({1'b0, r.meas_cov_xx}) + longint'({1'b0, c.filt_cov_xx});
         s01 = longint'($signed(r.meas_cov_xy)) + longint'($signed(c.filt_cov_xy));
         s02 = longint'($signed(r.meas_cov_xh)) + longint'($signed(c.filt_cov_xh));
         s11 = longint'({1'b0, r.meas_cov_yy}) + longint'({1'b0, c.filt_cov_yy});
         s12 = longint'($signed(r.meas_cov_yh)) + longint'($signed(c.filt_cov_yh));
         s22 = longint'({1'b0, r.meas_cov_hh}) + longint'({1'b0, c.filt_cov_hh});
         a00 = wide_type'(s11) * s22 - wide_type'(s12) * s12;
         a01 = wide_type'(s02) * s12 - wide_type'(s01) * s22;
         a02 = wide_type'(s01) * s12 - wide_type'(s02) * s11;
         a11 = wide_type'(s00) * s22 - wide_type'(s02) * s02;
         a12 = wide_type'(s01) * s02 - wide_type'(s00) * s12;
         a22 = wide_type'(s00) * s11 - wide_type'(s01) * s01;
         det = wide_type'(s00) * a00 + wide_type'(s01) * a01 + wide_type'(s02) * a02;
         if (s00 <= 0 || a22 <= 0 || det <= 0) begin
            v.dist_val = '0;
            v.st       = pmg3d_pkg::ST_NOT_PD;
         end else begin
            q   = a00 * (wide_type'(ix) * ix) + a11 * (wide_type'(iy) * iy)
                  + a22 * (wide_type'(ih) * ih);
            cr  = a01 * (wide_type'(ix) * iy) + a02 * (wide_type'(ix) * ih)
                  + a12 * (wide_type'(iy) * ih);
            q   = q + cr + cr;
            lim = det <<< 32;
            if ($unsigned(q) >= $unsigned(lim)) begin
               v.dist_val = 32'hFFFF_FFFF;
               v.st       = pmg3d_pkg::ST_SAT;
            end else begin
               v.dist_val = 32'($unsigned(q) / $unsigned(det));
               v.st       = pmg3d_pkg::ST_OK;
            end
         end
         expected_q.push_back(v);
      endfunction

      function void check(logic [31:0] act_dist, logic [1:0] st);
         verdict_type v;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: response with nothing outstanding: dist %h status %0d",
                        act_dist, st);
            return;
         end
         v = expected_q.pop_front();
         if (act_dist !== v.dist_val || st !== v.st) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: dist %h status %0d, expected dist %h status %0d",
                        act_dist, st, v.dist_val, v.st);
         end
      endfunction
   endclass

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   pmg3d_pkg::req_type                    req;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [31:0]                           rsp_dist_sq;
   logic [1:0]                            rsp_status;
   logic                                  csr_write_en;
   logic [pmg3d_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [pmg3d_pkg::CSR_DATA_W-1:0]      csr_wdata;

   gate_scoreboard     gate_sb = new();
   pmg3d_pkg::cfg_type filt_cfg;
   bit                 calm;          // no idling on either side while set
   bit                 stall_ask;     // receiver should hold off for a long stretch

   always #6 clock = ~clock;

   pose_mahalanobis_gate_3d_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_prop_x       (req.prop_x),
      .req_prop_y       (req.prop_y),
      .req_prop_heading (req.prop_heading),
      .req_est_x        (req.est_x),
      .req_est_y        (req.est_y),
      .req_est_heading  (req.est_heading),
      .req_meas_cov_xx  (req.meas_cov_xx),
      .req_meas_cov_xy  (req.meas_cov_xy),
      .req_meas_cov_xh  (req.meas_cov_xh),
      .req_meas_cov_yy  (req.meas_cov_yy),
      .req_meas_cov_yh  (req.meas_cov_yh),
      .req_meas_cov_hh  (req.meas_cov_hh),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dist_sq      (rsp_dist_sq),
      .rsp_status       (rsp_status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // response side: random back-pressure, or a long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_ask) begin
            stall_ask = 1'b0;
            rsp_ready <= 1'b0;
            // far longer than the pipeline depth so the chain fills and req_ready drops
            repeat (300) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 34);
         end
      end
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         gate_sb.check(rsp_dist_sq, rsp_status);
   end

   // symmetric random value in [-m, m]
   function automatic int sym(int m);
      return int'($urandom_range(2 * m)) - m;
   endfunction

   // offer one request, hold it until taken, then record the prediction
   task automatic send(pmg3d_pkg::req_type r);
      if (!calm && $urandom_range(99) < 51) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= r;
      do @(posedge clock); while (!req_ready);
      gate_sb.note(r, filt_cfg);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (gate_sb.expected_q.size() != 0) @(posedge clock);
      // one response per request, the extra cycles are only margin
      repeat (50) @(posedge clock);
   endtask

   // the caller drops csr_write_en after the last write of a burst
   task automatic write_csr(logic [pmg3d_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         pmg3d_pkg::CSR_FILT_COV_XX: filt_cfg.filt_cov_xx = data[30:0];
         pmg3d_pkg::CSR_FILT_COV_XY: filt_cfg.filt_cov_xy = data;
         pmg3d_pkg::CSR_FILT_COV_XH: filt_cfg.filt_cov_xh = data;
         pmg3d_pkg::CSR_FILT_COV_YY: filt_cfg.filt_cov_yy = data[30:0];
         pmg3d_pkg::CSR_FILT_COV_YH: filt_cfg.filt_cov_yh = data;
         pmg3d_pkg::CSR_FILT_COV_HH: filt_cfg.filt_cov_hh = data[30:0];
         default: ;
      endcase
   endtask

   task automatic load_filter(logic [31:0] xx, logic [31:0] xy, logic [31:0] xh,
                              logic [31:0] yy, logic [31:0] yh, logic [31:0] hh);
      write_csr(pmg3d_pkg::CSR_FILT_COV_XX, xx);
      write_csr(pmg3d_pkg::CSR_FILT_COV_XY, xy);
      write_csr(pmg3d_pkg::CSR_FILT_COV_XH, xh);
      write_csr(pmg3d_pkg::CSR_FILT_COV_YY, yy);
      write_csr(pmg3d_pkg::CSR_FILT_COV_YH, yh);
      write_csr(pmg3d_pkg::CSR_FILT_COV_HH, hh);
      csr_write_en <= 1'b0;
   endtask

   // well-formed request: positive definite covariance, moderate innovation
   function automatic pmg3d_pkg::req_type pose_req();
      pmg3d_pkg::req_type r;
      r.est_x        = $urandom;
      r.est_y        = $urandom;
      r.est_heading  = sym(1 << 20);
      r.prop_x       = r.est_x + sym(1 << 20);
      r.prop_y       = r.est_y + sym(1 << 20);
      // heading difference spans several turns so the wrap is exercised
      r.prop_heading = r.est_heading + sym(1 << 21);
      r.meas_cov_xx  = 31'($urandom_range(1 << 24, 1 << 14));
      r.meas_cov_yy  = 31'($urandom_range(1 << 24, 1 << 14));
      r.meas_cov_hh  = 31'($urandom_range(1 << 24, 1 << 14));
      r.meas_cov_xy  = sym(1 << 10);
      r.meas_cov_xh  = sym(1 << 10);
      r.meas_cov_yh  = sym(1 << 10);
      return r;
   endfunction

   // mostly well-formed, the rest full-range noise, a broken covariance or a saturating innovation
   function automatic pmg3d_pkg::req_type any_req();
      pmg3d_pkg::req_type r;
      int                 pick;
      pick = $urandom_range(99);
      r    = pose_req();
      if (pick < 15) begin
         r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      end else if (pick < 25) begin
         // large cross terms or an empty diagonal break positive definiteness
         r.meas_cov_xy = $urandom;
         r.meas_cov_yh = $urandom;
         if ($urandom_range(1)) r.meas_cov_xx = '0;
      end else if (pick < 30) begin
         // huge innovation against a tight covariance saturates
         r.prop_x      = r.est_x ^ 32'h8000_0000;
         r.meas_cov_xx = 1;
         r.meas_cov_yy = 1;
         r.meas_cov_hh = 1;
         r.meas_cov_xy = 0;
         r.meas_cov_xh = 0;
         r.meas_cov_yh = 0;
      end
      return r;
   endfunction

   task automatic run_random(int n);
      repeat (n) send(any_req());
   endtask

   task automatic run_directed();
      pmg3d_pkg::req_type r;
      // all zero: covariance not positive definite
      r = '0;
      send(r);
      // identity covariance, zero innovation
      r.meas_cov_xx = 31'h1_0000;
      r.meas_cov_yy = 31'h1_0000;
      r.meas_cov_hh = 31'h1_0000;
      send(r);
      // unit innovation in x, then in all three axes
      r.prop_x = 32'h1_0000;
      send(r);
      r.prop_y = 32'h1_0000;
      r.prop_heading = 32'h1_0000;
      send(r);
      // heading difference just past pi, just below minus pi, and many turns
      r.prop_x = 0;
      r.prop_y = 0;
      r.prop_heading = 32'sd205888;
      send(r);
      r.prop_heading = -32'sd205888;
      send(r);
      r.prop_heading = 32'sh7FFF_FFFF;
      r.est_heading  = 32'sh8000_0000;
      send(r);
      r.prop_heading = 32'sh8000_0000;
      r.est_heading  = 32'sh7FFF_FFFF;
      send(r);
      // extreme positions against the smallest covariance: saturates
      r.prop_x = 32'sh7FFF_FFFF;
      r.est_x  = 32'sh8000_0000;
      r.meas_cov_xx = 1;
      r.meas_cov_yy = 1;
      r.meas_cov_hh = 1;
      send(r);
      // largest diagonal, extreme off-diagonals
      r = '1;
      r.meas_cov_xx = 31'h7FFF_FFFF;
      r.meas_cov_xy = 32'sh8000_0000;
      r.meas_cov_xh = 32'sh7FFF_FFFF;
      r.meas_cov_yh = 32'sh8000_0000;
      send(r);
      r.prop_x = 32'sh8000_0000;
      r.est_x  = 32'sh7FFF_FFFF;
      r.meas_cov_xy = 0;
      r.meas_cov_xh = 0;
      r.meas_cov_yh = 0;
      send(r);
      // singular: x and y perfectly correlated
      r = pose_req();
      r.meas_cov_xx = 31'h10_0000;
      r.meas_cov_yy = 31'h10_0000;
      r.meas_cov_xy = 32'h10_0000;
      send(r);
      // the heading row and column are zero
      r = pose_req();
      r.meas_cov_hh = 0;
      r.meas_cov_xh = 0;
      r.meas_cov_yh = 0;
      send(r);
      repeat (6) send(pose_req());
   endtask

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req          <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      filt_cfg      = '0;
      calm          = 1'b0;
      stall_ask     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // filter covariance at its reset value of zero
      run_directed();
      run_random(100);
      drain();

      // largest filter covariance diagonal with extreme xy and xh cross terms
      load_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
      run_directed();
      run_random(60);
      drain();

      // typical filter covariance; long receiver hold-off, then a sender pause
      load_filter($urandom_range(1 << 20), sym(1 << 8), sym(1 << 8),
                  $urandom_range(1 << 20), sym(1 << 8), $urandom_range(1 << 20));
      stall_ask = 1'b1;
      run_random(80);
      req_valid <= 1'b0;
      while (gate_sb.expected_q.size() != 0) @(posedge clock);
      calm = 1'b1;
      run_random(80);
      calm = 1'b0;
      run_random(40);
      drain();

      // full-range random filter covariance
      load_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(100);
      drain();

      // back to zero written explicitly
      load_filter(0, 0, 0, 0, 0, 0);
      run_random(50);
      drain();

      if (gate_sb.mismatches == 0 && gate_sb.expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
